/* hw/rtl/cds_pkg.sv */
package cds_pkg;

  // Field widths of the channel payloads and the count register
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned CDF_W  = 20;
  localparam int unsigned SIZE_W = 21;
  localparam int unsigned RAND_W = 31;
  localparam int unsigned CNT_W  = 11;

  // Default table depth
  localparam int unsigned TABLE_DEPTH_DEF = 1024;

  // Fixed-point scale of the cumulative values (millionths)
  localparam int unsigned CDF_SCALE = 1000000;

  // floor(2^RECIP_SHIFT / CDF_SCALE), used to estimate the quotient
  localparam int unsigned RECIP_SHIFT = 50;
  localparam logic [RAND_W-1:0] RECIP = 31'd1125899906;

  // Quotient of a random word by CDF_SCALE fits in this many bits
  localparam int unsigned QUOT_W = 12;

  // Function codes of an input transaction
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic wr_en;     // write the table entry of the current transaction
    logic cap_rand;  // capture the random word
    logic mul;       // estimate the quotient
    logic sub;       // form the raw remainder
    logic init;      // correct the remainder, set search bounds, first read
    logic step;      // one search probe
    logic load_out;  // load the output register
  } cds_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic last_zero;  // only one entry in use
    logic step_done;  // search bounds meet after this probe
  } cds_stat_t;

endpackage

/* hw/rtl/cds_if.sv */
interface cds_req_if;
  import cds_pkg::*;

  logic              valid;
  logic              ready;
  logic              func;
  logic [IDX_W-1:0]  entry_index;
  logic [CDF_W-1:0]  entry_cdf;
  logic [SIZE_W-1:0] entry_size;
  logic [RAND_W-1:0] random_value;

  modport source (
    output valid, func, entry_index, entry_cdf, entry_size, random_value,
    input  ready
  );

  modport sink (
    input  valid, func, entry_index, entry_cdf, entry_size, random_value,
    output ready
  );
endinterface

interface cds_rsp_if;
  import cds_pkg::*;

  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  selected_index;
  logic [SIZE_W-1:0] selected_size;

  modport source (
    output valid, selected_index, selected_size,
    input  ready
  );

  modport sink (
    input  valid, selected_index, selected_size,
    output ready
  );
endinterface

/* hw/rtl/cds_datapath.sv */
module cds_datapath #(
  parameter int unsigned TABLE_DEPTH = cds_pkg::TABLE_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [cds_pkg::CNT_W-1:0]  cfg_wdata_i,
  input  cds_pkg::cds_cmd_t          cmd_i,
  output cds_pkg::cds_stat_t         stat_o,
  input  logic [cds_pkg::IDX_W-1:0]  entry_index_i,
  input  logic [cds_pkg::CDF_W-1:0]  entry_cdf_i,
  input  logic [cds_pkg::SIZE_W-1:0] entry_size_i,
  input  logic [cds_pkg::RAND_W-1:0] random_value_i,
  output logic [cds_pkg::IDX_W-1:0]  selected_index_o,
  output logic [cds_pkg::SIZE_W-1:0] selected_size_o
);
  import cds_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  // Table storage
  logic [CDF_W-1:0]  cdf_mem  [TABLE_DEPTH];
  logic [SIZE_W-1:0] size_mem [TABLE_DEPTH];

  logic [AW-1:0]     last_q, last_d;
  logic [RAND_W-1:0] rand_q;
  logic [QUOT_W-1:0] quot_q;
  logic [SIZE_W-1:0] rem_q;
  logic [CDF_W-1:0]  target_q;
  logic [AW-1:0]     lo_q, hi_q, mid_q;
  logic [CDF_W-1:0]  cdf_rd_q;
  logic [SIZE_W-1:0] size_rd_q;
  logic [IDX_W-1:0]  sel_index_q;
  logic [SIZE_W-1:0] sel_size_q;

  logic [2*RAND_W-1:0] prod;
  logic [31:0]         quot_scaled;
  logic [31:0]         diff;
  logic                slot_ok;
  logic                below;
  logic [AW-1:0]       lo_d, hi_d, mid_d;
  logic [AW:0]         bound_sum;
  logic                done;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;

  // Clamp the written entry count to 1..TABLE_DEPTH, keep the last index in use
  always_comb begin
    if (32'(cfg_wdata_i) > 32'(TABLE_DEPTH)) begin
      last_d = AW'(TABLE_DEPTH - 1);
    end else if (cfg_wdata_i == '0) begin
      last_d = '0;
    end else begin
      last_d = AW'(cfg_wdata_i - CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else if (cfg_we_i) begin
      last_q <= last_d;
    end
  end

  // Modulo reduction: quotient estimate, raw remainder, one correction
  assign prod        = rand_q * RECIP;
  assign quot_scaled = 32'(quot_q) * 32'(CDF_SCALE);
  assign diff        = 32'(rand_q) - quot_scaled;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_rand) begin
      rand_q <= random_value_i;
    end
    if (cmd_i.mul) begin
      quot_q <= prod[RECIP_SHIFT +: QUOT_W];
    end
    if (cmd_i.sub) begin
      rem_q <= diff[SIZE_W-1:0];
    end
    if (cmd_i.init) begin
      if (rem_q >= SIZE_W'(CDF_SCALE)) begin
        target_q <= CDF_W'(rem_q - SIZE_W'(CDF_SCALE));
      end else begin
        target_q <= rem_q[CDF_W-1:0];
      end
    end
  end

  // One search probe: narrow the bounds and pick the next read address
  assign below     = cdf_rd_q < target_q;
  assign lo_d      = below ? mid_q + AW'(1) : lo_q;
  assign hi_d      = below ? hi_q : mid_q;
  assign bound_sum = {1'b0, lo_d} + {1'b0, hi_d};
  assign mid_d     = bound_sum[AW:1];
  assign done      = lo_d >= hi_d;

  assign rd_en   = cmd_i.init | cmd_i.step;
  assign rd_addr = cmd_i.init ? (last_q >> 1) : (done ? lo_d : mid_d);

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      lo_q <= '0;
      hi_q <= last_q;
    end else if (cmd_i.step) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
    if (rd_en) begin
      mid_q <= rd_addr;
    end
  end

  // Table write and registered read
  assign slot_ok = 32'(entry_index_i) < 32'(TABLE_DEPTH);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && slot_ok) begin
      cdf_mem[AW'(entry_index_i)]  <= entry_cdf_i;
      size_mem[AW'(entry_index_i)] <= entry_size_i;
    end
    if (rd_en) begin
      cdf_rd_q  <= cdf_mem[rd_addr];
      size_rd_q <= size_mem[rd_addr];
    end
  end

  // Output register; mid_q holds the final index once the search ends
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      sel_index_q <= IDX_W'(mid_q);
      sel_size_q  <= size_rd_q;
    end
  end

  assign stat_o.last_zero = last_q == '0;
  assign stat_o.step_done = done;

  assign selected_index_o = sel_index_q;
  assign selected_size_o  = sel_size_q;

endmodule

/* hw/rtl/cds_controller.sv */
module cds_controller (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  logic                req_func_i,
  output logic                req_ready_o,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  input  cds_pkg::cds_stat_t  stat_i,
  output cds_pkg::cds_cmd_t   cmd_o
);
  import cds_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_SUB  = 6'b000100,
    ST_FIX  = 6'b001000,
    ST_SRCH = 6'b010000,
    ST_READ = 6'b100000
  } cds_state_e;

  cds_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       out_free;

  assign req_ready_o = state_q == ST_IDLE;
  assign accept      = req_valid_i && req_ready_o;
  assign out_free    = !out_valid_q || rsp_ready_i;

  // Take loads; sequence a sample through reduction, search, result load
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_func_i == FUNC_SAMPLE) begin
            cmd_o.cap_rand = 1'b1;
            state_d        = ST_MUL;
          end else begin
            cmd_o.wr_en = 1'b1;
          end
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_SUB;
      end
      ST_SUB: begin
        cmd_o.sub = 1'b1;
        state_d   = ST_FIX;
      end
      ST_FIX: begin
        cmd_o.init = 1'b1;
        state_d    = stat_i.last_zero ? ST_READ : ST_SRCH;
      end
      ST_SRCH: begin
        cmd_o.step = 1'b1;
        if (stat_i.step_done) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        // hold until the output register is free
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign rsp_valid_o = out_valid_q;

endmodule

/* hw/rtl/cdf_table_sampler.sv */
// Channel  | Dir | Carries
// ---------+-----+--------------------------------------------------------------
// req_i    | in  | func, entry_index, entry_cdf, entry_size, random_value
// rsp_o    | out | selected_index, selected_size (one per sample transaction)
// cfg      | in  | cfg_we_i / cfg_wdata_i: entry_count, write-only
//
// A load transaction writes one table entry at its accept edge; loads go back to back.
// A sample holds off the next accept until it is done: multiply, multiply-subtract and
// correction for the modulo, one table read per search probe (the last also fetches the
// size), then the output load, which waits while the output register is still full.
// Reset clears control only: entry_count returns to 1, table contents are undefined.
// A stalled result waits in the output register; a second result waits behind it.
module cdf_table_sampler #(
  parameter int unsigned TABLE_DEPTH = cds_pkg::TABLE_DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [cds_pkg::CNT_W-1:0] cfg_wdata_i,
  cds_req_if.sink                   req_i,
  cds_rsp_if.source                 rsp_o
);
  import cds_pkg::*;

  cds_cmd_t  cmd;
  cds_stat_t stat;

  cds_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_func_i  (req_i.func),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  cds_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .entry_index_i    (req_i.entry_index),
    .entry_cdf_i      (req_i.entry_cdf),
    .entry_size_i     (req_i.entry_size),
    .random_value_i   (req_i.random_value),
    .selected_index_o (rsp_o.selected_index),
    .selected_size_o  (rsp_o.selected_size)
  );

endmodule
